[rtl/fdsd_pkg.sv]
// ----------------------------------------------------------------------------
// fdsd_pkg
// Shared constants for the frame difference shot detector: field widths,
// register indexes, luma weights and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsd_pkg;

    // Default size of the frame store in pixels.
    localparam int DEF_MAX_PIXELS = 65536;

    // Field widths.
    localparam int COLOR_W  = 8;
    localparam int GRAY_W   = 8;
    localparam int FRAME_W  = 24;
    localparam int SHOT_W   = 16;
    localparam int SUM_W    = 24;
    localparam int CFG_FP_W = 17;
    localparam int CFG_TH_W = 8;

    // Pixel count arithmetic covers a store of up to 2^24 pixels.
    localparam int CNT_W = 25;
    // Threshold times pixel count.
    localparam int LIM_W = CNT_W + CFG_TH_W;

    // APB port geometry.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_FRAME_PIXELS   = 1'b0;
    localparam logic REG_DIFF_THRESHOLD = 1'b1;

    // Register reset values.
    localparam logic [CFG_FP_W-1:0] RST_FRAME_PIXELS   = 17'd65536;
    localparam logic [CFG_TH_W-1:0] RST_DIFF_THRESHOLD = 8'd10;

    // Fixed-point luma weights (sum to 2^14) and rounding term.
    localparam int LUMA_SHIFT = 14;
    localparam int PB_W       = 19;
    localparam int PG_W       = 22;
    localparam int PR_W       = 21;
    localparam int LSUM_W     = 22;
    localparam logic [10:0] W_BLUE  = 11'd1868;
    localparam logic [13:0] W_GREEN = 14'd9617;
    localparam logic [12:0] W_RED   = 13'd4899;
    localparam logic [LSUM_W-1:0] LUMA_ROUND = 22'd8192;

    // Saturation limit of the frame sum.
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

`default_nettype wire

[rtl/fdsd_ram.sv]
// ----------------------------------------------------------------------------
// fdsd_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while the read is disabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/frame_difference_shot_detector_unit.sv]
// ----------------------------------------------------------------------------
// frame_difference_shot_detector_unit
// Converts BGR pixels to gray, compares each one with the same position of
// the previous frame held in a frame store, sums the absolute differences
// and reports once per frame (after the first) whether the mean difference
// exceeds a threshold.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                  Direction  Beat
//  -------   -------------------------------------    ---------  ---------------
//  pixel     i_in_valid/o_in_ready, i_blue..i_red     in         one pixel
//  result    o_out_valid/i_out_ready, o_shot_...      out        one frame report
//  config    psel/penable/pwrite/paddr/pwdata/prdata  in/out     one register
//
// One pixel beat is taken every cycle while the pipeline does not hold; a frame
// report is loaded into the result register once the beat of the frame's last
// pixel has passed stages 1, 2 and 3. The rate is set by the frame store, which
// takes one read and one write per cycle. Reset is synchronous and needs no
// clearing pass: stored values are only used after the first frame wrote them.
// The whole pipeline holds only when a report must be loaded while the
// previous one still waits on i_out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_difference_shot_detector_unit #(
    parameter int MAX_PIXELS = fdsd_pkg::DEF_MAX_PIXELS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    // Pixel channel.
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [fdsd_pkg::COLOR_W-1:0]   i_blue,
    input  wire logic [fdsd_pkg::COLOR_W-1:0]   i_green,
    input  wire logic [fdsd_pkg::COLOR_W-1:0]   i_red,

    // Result channel.
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_shot_detected,
    output logic [fdsd_pkg::FRAME_W-1:0]        o_frame_number,
    output logic [fdsd_pkg::SHOT_W-1:0]         o_shot_count,
    output logic [fdsd_pkg::SUM_W-1:0]          o_difference_sum,

    // Configuration port.
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fdsd_pkg::APB_AW-1:0]    paddr,
    input  wire logic [fdsd_pkg::APB_DW-1:0]    pwdata,
    output logic [fdsd_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    import fdsd_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    // Configuration registers and derived values.
    logic [CFG_FP_W-1:0] r_frame_pixels;
    logic [CFG_TH_W-1:0] r_diff_threshold;
    logic [CNT_W-1:0]    w_count;
    logic [LIM_W-1:0]    r_limit;
    logic                w_cfg_wr;

    // Input side position counter.
    logic [AW-1:0]       r_pos;
    logic                w_last;
    logic                w_accept;
    logic                w_adv;

    // Stage 1: captured pixel, store read in flight.
    logic                r_s1_valid;
    logic [COLOR_W-1:0]  r_s1_blue;
    logic [COLOR_W-1:0]  r_s1_green;
    logic [COLOR_W-1:0]  r_s1_red;
    logic [AW-1:0]       r_s1_pos;
    logic                r_s1_last;
    logic [GRAY_W-1:0]   w_ram_rdata;
    logic [GRAY_W-1:0]   w_s1_old;

    // Stage 2: weighted components and previous gray value.
    logic                r_s2_valid;
    logic [PB_W-1:0]     r_s2_pb;
    logic [PG_W-1:0]     r_s2_pg;
    logic [PR_W-1:0]     r_s2_pr;
    logic [GRAY_W-1:0]   r_s2_old;
    logic [AW-1:0]       r_s2_pos;
    logic                r_s2_last;
    logic [LSUM_W-1:0]   w_s2_lsum;
    logic [GRAY_W-1:0]   w_s2_gray;
    logic [GRAY_W-1:0]   w_s2_diff;

    // Stage 3: gray value and absolute difference.
    logic                r_s3_valid;
    logic [GRAY_W-1:0]   r_s3_gray;
    logic [GRAY_W-1:0]   r_s3_diff;
    logic [AW-1:0]       r_s3_pos;
    logic                r_s3_last;

    // Frame accumulation state.
    logic                r_have_prev;
    logic [SUM_W-1:0]    r_running;
    logic [FRAME_W-1:0]  r_frames;
    logic [SHOT_W-1:0]   r_shots;
    logic [SUM_W:0]      w_sum_wide;
    logic [SUM_W-1:0]    n_running;
    logic [FRAME_W-1:0]  n_frames;
    logic                w_shot;
    logic                w_emit;

    // Result register.
    logic                r_out_valid;
    logic                r_out_shot;
    logic [FRAME_W-1:0]  r_out_frame;
    logic [SHOT_W-1:0]   r_out_shots;
    logic [SUM_W-1:0]    r_out_sum;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // Writes complete in the access phase; the port never waits.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels   <= RST_FRAME_PIXELS;
            r_diff_threshold <= RST_DIFF_THRESHOLD;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_FRAME_PIXELS:   r_frame_pixels   <= pwdata[CFG_FP_W-1:0];
                REG_DIFF_THRESHOLD: r_diff_threshold <= pwdata[CFG_TH_W-1:0];
                default:            r_frame_pixels   <= r_frame_pixels;
            endcase
        end
    end

    // Read data.
    always_comb begin
        case (paddr[2])
            REG_FRAME_PIXELS:   prdata = APB_DW'(r_frame_pixels);
            REG_DIFF_THRESHOLD: prdata = APB_DW'(r_diff_threshold);
            default:            prdata = '0;
        endcase
    end

    // Pixel count in use: zero acts as one, and the count stops at the store size.
    always_comb begin
        if (r_frame_pixels == '0) begin
            w_count = CNT_W'(1);
        end else if (CNT_W'(r_frame_pixels) > CNT_W'(MAX_PIXELS)) begin
            w_count = CNT_W'(MAX_PIXELS);
        end else begin
            w_count = CNT_W'(r_frame_pixels);
        end
    end

    // Threshold times pixel count, used only at the end of a frame.
    always_ff @(posedge i_clk) begin
        r_limit <= LIM_W'(r_diff_threshold) * LIM_W'(w_count);
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------

    // The pipeline moves unless a new report meets a report still waiting.
    assign w_emit     = r_s3_valid && r_s3_last && r_have_prev;
    assign w_adv      = !(r_out_valid && !i_out_ready && w_emit);
    assign o_in_ready = w_adv;
    assign w_accept   = i_in_valid && w_adv;

    // ------------------------------------------------------------------
    // Stage 0: position counter and store read
    // ------------------------------------------------------------------

    assign w_last = (CNT_W'(r_pos) + CNT_W'(1)) >= w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_accept) begin
            r_pos <= w_last ? '0 : r_pos + AW'(1);
        end
    end

    fdsd_ram #(
        .WIDTH (GRAY_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid && w_adv),
        .i_waddr (r_s2_pos),
        .i_wdata (w_s2_gray),
        .i_re    (w_adv),
        .i_raddr (r_pos),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: weights, and forward gray values not yet in the store
    // ------------------------------------------------------------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_blue  <= i_blue;
            r_s1_green <= i_green;
            r_s1_red   <= i_red;
            r_s1_pos   <= r_pos;
            r_s1_last  <= w_last;
        end
    end

    // The two pixels ahead may still be writing the same position.
    always_comb begin
        if (r_s2_valid && (r_s2_pos == r_s1_pos)) begin
            w_s1_old = w_s2_gray;
        end else if (r_s3_valid && (r_s3_pos == r_s1_pos)) begin
            w_s1_old = r_s3_gray;
        end else begin
            w_s1_old = w_ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_pb   <= PB_W'(r_s1_blue) * PB_W'(W_BLUE);
            r_s2_pg   <= PG_W'(r_s1_green) * PG_W'(W_GREEN);
            r_s2_pr   <= PR_W'(r_s1_red) * PR_W'(W_RED);
            r_s2_old  <= w_s1_old;
            r_s2_pos  <= r_s1_pos;
            r_s2_last <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rounded gray value and absolute difference
    // ------------------------------------------------------------------

    assign w_s2_lsum = LSUM_W'(r_s2_pb) + r_s2_pg + LSUM_W'(r_s2_pr) + LUMA_ROUND;
    assign w_s2_gray = w_s2_lsum[LSUM_W-1:LUMA_SHIFT];
    assign w_s2_diff = (w_s2_gray > r_s2_old) ? (w_s2_gray - r_s2_old)
                                              : (r_s2_old - w_s2_gray);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_gray <= w_s2_gray;
            r_s3_diff <= w_s2_diff;
            r_s3_pos  <= r_s2_pos;
            r_s3_last <= r_s2_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: frame sum, frame and shot counters, report
    // ------------------------------------------------------------------

    // Saturating sum; the first frame only fills the store.
    assign w_sum_wide = {1'b0, r_running} + (SUM_W + 1)'(r_s3_diff);
    always_comb begin
        if (!r_have_prev) begin
            n_running = r_running;
        end else if (w_sum_wide[SUM_W]) begin
            n_running = SUM_MAX;
        end else begin
            n_running = w_sum_wide[SUM_W-1:0];
        end
    end

    assign n_frames = r_frames + FRAME_W'(1);
    assign w_shot   = LIM_W'(n_running) > r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_running   <= '0;
            r_frames    <= '0;
            r_shots     <= '0;
        end else if (w_adv && r_s3_valid) begin
            if (r_s3_last) begin
                r_have_prev <= 1'b1;
                r_running   <= '0;
                r_frames    <= n_frames;
                if (r_have_prev && w_shot) begin
                    r_shots <= r_shots + SHOT_W'(1);
                end
            end else begin
                r_running <= n_running;
            end
        end
    end

    // Result register: loaded at the end of each reported frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_shot  <= w_shot;
            r_out_frame <= n_frames;
            r_out_shots <= w_shot ? r_shots + SHOT_W'(1) : r_shots;
            r_out_sum   <= n_running;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_shot_detected  = r_out_shot;
    assign o_frame_number   = r_out_frame;
    assign o_shot_count     = r_out_shots;
    assign o_difference_sum = r_out_sum;

endmodule

`default_nettype wire
